FILE: sv/prs_pkg.sv
// prs_pkg: shared constants, codes, state encoding and helpers for the packed row sprite scaler
// no dependencies; compiled first
package prs_pkg;

  localparam int PAL_ENTRIES = 32;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int FRAC_BITS   = 12;
  localparam int COLOR_W     = 16;
  localparam int X_W         = 21;
  localparam int Y_W         = 16;
  localparam int LEN_W       = 8;
  localparam int XS_W        = 16;
  localparam int PROD_W      = LEN_W + XS_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int CNT_W       = ACC_W - FRAC_BITS;
  localparam int MAX_RESULTS = 64;
  localparam int PIX_W       = $clog2(MAX_RESULTS) + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [2:0] RUN_MASK = 3'h7;

  localparam logic signed [X_W-1:0] CUR_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] CUR_MIN = {1'b1, {(X_W-1){1'b0}}};

  // request and result codes
  localparam logic OP_ROW_BYTE  = 1'b0;
  localparam logic OP_PALETTE   = 1'b1;
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_INVALID   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOGICAL_WIDTH   = 3'd0,
    CFG_X_SCALE         = 3'd1,
    CFG_START_REMAINDER = 3'd2,
    CFG_X_STEP_LEFT     = 3'd3,
    CFG_ORIGIN_X        = 3'd4,
    CFG_SURFACE_WIDTH   = 3'd5,
    CFG_SURFACE_HEIGHT  = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_SCALE = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // clamp a widened cursor sum into the signed cursor range
  function automatic logic signed [X_W-1:0] sat_cursor(input logic signed [X_W+1:0] v);
    logic signed [X_W+1:0] hi;
    logic signed [X_W+1:0] lo;
    hi = {{2{CUR_MAX[X_W-1]}}, CUR_MAX};
    lo = {{2{CUR_MIN[X_W-1]}}, CUR_MIN};
    if (v > hi) begin
      sat_cursor = CUR_MAX;
    end else if (v < lo) begin
      sat_cursor = CUR_MIN;
    end else begin
      sat_cursor = v[X_W-1:0];
    end
  endfunction

  // cursor moved by step_len in the chosen direction, saturating
  function automatic logic signed [X_W-1:0] move_cursor(input logic signed [X_W-1:0] cur,
                                                          input logic [CNT_W-1:0] step_len,
                                                          input logic left);
    logic signed [X_W+1:0] wide;
    logic signed [X_W+1:0] d;
    wide = {{2{cur[X_W-1]}}, cur};
    d    = {{(X_W+2-CNT_W){1'b0}}, step_len};
    move_cursor = sat_cursor(left ? (wide - d) : (wide + d));
  endfunction

endpackage

FILE: sv/prs_if.sv
// prs_in_if and prs_out_if: valid/ready channels for row and palette requests and for results
// depends on nothing; widths follow the request and result field definitions
interface prs_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         data_byte;
  logic signed [15:0] row_y;
  logic [4:0]         palette_index;
  logic [15:0]        palette_value;

  modport source(output valid, operation, data_byte, row_y, palette_index, palette_value,
                 input ready);
  modport sink(input valid, operation, data_byte, row_y, palette_index, palette_value,
               output ready);
endinterface

interface prs_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [20:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [15:0]        blend_color;
  logic               visible;
  logic               status;
  logic               last;

  modport source(output valid, kind, pixel_x, pixel_y, blend_color, visible, status, last,
                 input ready);
  modport sink(input valid, kind, pixel_x, pixel_y, blend_color, visible, status, last,
               output ready);
endinterface

FILE: sv/prs_ram.sv
// prs_ram: generic single write port, single read port ram with registered read data
// no dependencies
module prs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/prs_scale.sv
// prs_scale: segment length times x_scale, registered, then added to the 12-bit fraction
// depends on prs_pkg
module prs_scale (
  input  logic                            clk,
  input  logic                            mul_en,
  input  logic [prs_pkg::LEN_W-1:0]       seg_len,
  input  logic [prs_pkg::XS_W-1:0]        x_scale,
  input  logic [prs_pkg::FRAC_BITS-1:0]   frac_in,
  output logic [prs_pkg::CNT_W-1:0]       cnt,
  output logic [prs_pkg::FRAC_BITS-1:0]   frac_out
);
  import prs_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= {{XS_W{1'b0}}, seg_len} * {{LEN_W{1'b0}}, x_scale};
    end
  end

  assign acc      = {{(ACC_W-FRAC_BITS){1'b0}}, frac_in} + {1'b0, prod_r};
  assign frac_out = acc[FRAC_BITS-1:0];
  assign cnt      = acc[ACC_W-1:FRAC_BITS];

endmodule

FILE: sv/packed_row_sprite_scaler.sv
// packed_row_sprite_scaler: top level, row byte decoder, cursor, pixel sequencer and palette ram
// depends on prs_pkg, prs_in_if/prs_out_if, prs_ram and prs_scale
// a palette write or a row byte that moves nothing is handled in the accept state; a start column or
// skip passes through S_IDLE (accept), S_MUL (multiply) and S_SCALE (accumulate); a run also sends
// its pixels, then a row-finished result if it ends the row; pixel output, one per cycle while
// out_ch.ready is high, sets the sustained rate; reset (synchronous, rst_n low) loads the register
// defaults and clears the row state; the palette ram is not cleared and holds whatever was written
module packed_row_sprite_scaler (
  input  logic                              clk,
  input  logic                              rst_n,
  prs_in_if.sink                            in_ch,
  prs_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import prs_pkg::*;

  // configuration registers
  logic [15:0]        lw_r;
  logic [XS_W-1:0]    xs_r;
  logic [FRAC_BITS-1:0] srem_r;
  logic               left_r;
  logic signed [15:0] org_r;
  logic [12:0]        sw_r;
  logic [12:0]        sh_r;

  // row decoding state
  state_t               state_r, state_nxt;
  logic [7:0]           row_len_r, row_len_nxt;
  logic [7:0]           bc_r, bc_nxt;
  logic [15:0]          sc_r, sc_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic signed [X_W-1:0] cur_r, cur_nxt;
  logic                 await_r, await_nxt;
  logic                 failed_r, failed_nxt;

  // per request work registers
  logic [LEN_W-1:0]     seg_len_r, seg_len_nxt;
  logic                 seg_pix_r, seg_pix_nxt;
  logic                 ends_r, ends_nxt;
  logic                 done_st_r, done_st_nxt;
  logic signed [Y_W-1:0] y_r, y_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic signed [X_W-1:0] px_r, px_nxt;
  logic [PIX_W-1:0]     left_cnt_r, left_cnt_nxt;

  logic                 acc_in;
  logic                 out_take;
  logic [7:0]           b;
  logic [7:0]           bc_inc;
  logic                 ends;
  logic                 room_ok;
  logic [15:0]          room;
  logic [7:0]           run_len;
  logic [COLOR_W-1:0]   pal_rdata;
  logic [CNT_W-1:0]     seg_cnt;
  logic [FRAC_BITS-1:0] seg_frac;
  logic [CNT_W-1:0]     budget;
  logic [CNT_W-1:0]     npix;
  logic                 vis;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign out_take    = out_ch.valid && out_ch.ready;

  assign b       = in_ch.data_byte;
  assign bc_inc  = bc_r + 8'd1;
  assign ends    = (bc_inc >= row_len_r);
  // space left in the source row; none is checked if the column already lies beyond the width
  assign room_ok = (lw_r >= sc_r);
  assign room    = lw_r - sc_r;
  assign run_len = {5'd0, b[2:0] & RUN_MASK} + 8'd1;

  // palette store, read at the run's colour index when the byte is taken
  prs_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_ENTRIES)) u_pal_ram (
    .clk   (clk),
    .we    (acc_in && (in_ch.operation == OP_PALETTE)),
    .waddr (in_ch.palette_index),
    .wdata (in_ch.palette_value),
    .raddr (b[7:3]),
    .rdata (pal_rdata)
  );

  // shared fractional scaler for start column, skips and runs
  prs_scale u_scale (
    .clk      (clk),
    .mul_en   (state_r == S_MUL),
    .seg_len  (seg_len_r),
    .x_scale  (xs_r),
    .frac_in  (frac_r),
    .cnt      (seg_cnt),
    .frac_out (seg_frac)
  );

  // the row-finished result takes one slot when the run ends its row
  assign budget = ends_r ? CNT_W'(MAX_RESULTS - 1) : CNT_W'(MAX_RESULTS);
  assign npix   = !seg_pix_r ? '0 : ((seg_cnt > budget) ? budget : seg_cnt);

  always_comb begin
    state_nxt    = state_r;
    row_len_nxt  = row_len_r;
    bc_nxt       = bc_r;
    sc_nxt       = sc_r;
    frac_nxt     = frac_r;
    cur_nxt      = cur_r;
    await_nxt    = await_r;
    failed_nxt   = failed_r;
    seg_len_nxt  = seg_len_r;
    seg_pix_nxt  = seg_pix_r;
    ends_nxt     = ends_r;
    done_st_nxt  = done_st_r;
    y_nxt        = y_r;
    color_nxt    = color_r;
    px_nxt       = px_r;
    left_cnt_nxt = left_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc_in && (in_ch.operation == OP_ROW_BYTE)) begin
          y_nxt = in_ch.row_y;
          if (bc_r == 8'd0) begin
            // size byte opens a new row
            row_len_nxt = b;
            sc_nxt      = '0;
            frac_nxt    = srem_r;
            await_nxt   = 1'b0;
            failed_nxt  = (b == 8'd2);
            if (b == 8'd0) begin
              done_st_nxt = ST_INVALID;
              state_nxt   = S_DONE;
            end else if (b == 8'd1) begin
              done_st_nxt = ST_OK;
              state_nxt   = S_DONE;
            end else begin
              bc_nxt = 8'd1;
            end
          end else begin
            seg_pix_nxt = 1'b0;
            ends_nxt    = ends;
            state_nxt   = S_IDLE;
            if (!failed_r) begin
              if (bc_inc == 8'd2) begin
                // start column
                if ({8'd0, b} > lw_r) begin
                  failed_nxt = 1'b1;
                end else begin
                  sc_nxt      = {8'd0, b};
                  cur_nxt     = {{(X_W-16){org_r[15]}}, org_r};
                  seg_len_nxt = b;
                  state_nxt   = S_MUL;
                end
              end else if (await_r) begin
                await_nxt = 1'b0;
                if (room_ok && ({8'd0, b} > room)) begin
                  failed_nxt = 1'b1;
                end else begin
                  sc_nxt      = sc_r + {8'd0, b};
                  seg_len_nxt = b;
                  state_nxt   = S_MUL;
                end
              end else if (b == 8'd0) begin
                // zero packet: skip count follows, unless the row ends here
                if (ends) begin
                  failed_nxt = 1'b1;
                end else begin
                  await_nxt = 1'b1;
                end
              end else begin
                if (room_ok && ({8'd0, run_len} > room)) begin
                  failed_nxt = 1'b1;
                end else begin
                  sc_nxt      = sc_r + {8'd0, run_len};
                  seg_len_nxt = run_len;
                  seg_pix_nxt = 1'b1;
                  state_nxt   = S_MUL;
                end
              end
            end
            if (ends) begin
              bc_nxt    = 8'd0;
              await_nxt = 1'b0;
              if (state_nxt == S_IDLE) begin
                state_nxt = S_DONE;
              end
            end else begin
              bc_nxt = bc_inc;
            end
            done_st_nxt = failed_nxt ? ST_INVALID : ST_OK;
          end
        end
      end
      S_MUL: begin
        // palette read data is valid in the cycle after the byte was taken
        color_nxt = pal_rdata;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        frac_nxt     = seg_frac;
        cur_nxt      = move_cursor(cur_r, seg_cnt, left_r);
        px_nxt       = cur_r;
        left_cnt_nxt = npix[PIX_W-1:0];
        if (npix != '0) begin
          state_nxt = S_EMIT;
        end else if (ends_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_take) begin
          px_nxt       = move_cursor(px_r, CNT_W'(1), left_r);
          left_cnt_nxt = left_cnt_r - PIX_W'(1);
          if (left_cnt_r == PIX_W'(1)) begin
            state_nxt = ends_r ? S_DONE : S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (out_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_len_r <= '0;
      bc_r      <= '0;
      sc_r      <= '0;
      frac_r    <= '0;
      cur_r     <= '0;
      await_r   <= 1'b0;
      failed_r  <= 1'b0;
      lw_r      <= 16'd256;
      xs_r      <= 16'd4096;
      srem_r    <= '0;
      left_r    <= 1'b0;
      org_r     <= '0;
      sw_r      <= 13'd320;
      sh_r      <= 13'd240;
    end else begin
      state_r   <= state_nxt;
      row_len_r <= row_len_nxt;
      bc_r      <= bc_nxt;
      sc_r      <= sc_nxt;
      frac_r    <= frac_nxt;
      cur_r     <= cur_nxt;
      await_r   <= await_nxt;
      failed_r  <= failed_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LOGICAL_WIDTH:   lw_r   <= cfg_data;
          CFG_X_SCALE:         xs_r   <= cfg_data;
          CFG_START_REMAINDER: srem_r <= cfg_data[FRAC_BITS-1:0];
          CFG_X_STEP_LEFT:     left_r <= cfg_data[0];
          CFG_ORIGIN_X:        org_r  <= cfg_data;
          CFG_SURFACE_WIDTH:   sw_r   <= cfg_data[12:0];
          CFG_SURFACE_HEIGHT:  sh_r   <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    seg_len_r  <= seg_len_nxt;
    seg_pix_r  <= seg_pix_nxt;
    ends_r     <= ends_nxt;
    done_st_r  <= done_st_nxt;
    y_r        <= y_nxt;
    color_r    <= color_nxt;
    px_r       <= px_nxt;
    left_cnt_r <= left_cnt_nxt;
  end

  // clip test against the destination surface
  assign vis = !px_r[X_W-1] && !y_r[Y_W-1] &&
               ({7'd0, px_r[X_W-2:0]} < {14'd0, sw_r}) &&
               ({2'd0, y_r[Y_W-2:0]} < {4'd0, sh_r});

  // result channel, driven from the work registers
  assign out_ch.valid       = (state_r == S_EMIT) || (state_r == S_DONE);
  assign out_ch.kind        = (state_r == S_DONE) ? KIND_ROW_END : KIND_PIXEL;
  assign out_ch.pixel_x     = (state_r == S_EMIT) ? px_r : '0;
  assign out_ch.pixel_y     = (state_r == S_EMIT) ? y_r : '0;
  assign out_ch.blend_color = (state_r == S_EMIT) ? color_r : '0;
  assign out_ch.visible     = (state_r == S_EMIT) && vis;
  assign out_ch.status      = (state_r == S_DONE) ? done_st_r : ST_OK;
  // the last pixel of a run is final only when no row-finished result follows
  assign out_ch.last        = (state_r == S_DONE) ||
                              ((left_cnt_r == PIX_W'(1)) && !ends_r);

endmodule

FILE: sv/prs_checker.sv
// prs_checker: port-level assertions for the packed row sprite scaler, bound to the top level
// depends on packed_row_sprite_scaler and its channel interfaces
module prs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_kind,
  input logic signed [20:0] out_pixel_x,
  input logic               out_visible,
  input logic               out_status,
  input logic               out_last
);

  // one request at a time: no new request while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("request taken while a result is pending");

  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> out_last)
    else $error("row-finished result not marked last");

  a_pixel_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> !out_status)
    else $error("pixel result carries a row status");

  a_visible_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind && out_visible) |-> !out_pixel_x[20])
    else $error("visible pixel with negative column");

endmodule

bind packed_row_sprite_scaler prs_checker u_prs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_kind    (out_ch.kind),
  .out_pixel_x (out_ch.pixel_x),
  .out_visible (out_ch.visible),
  .out_status  (out_ch.status),
  .out_last    (out_ch.last)
);
